### rtl/arp_reply_builder_top_macros.svh
// assertion macros for the arp reply builder
`ifndef ARP_REPLY_BUILDER_TOP_MACROS_SVH
`define ARP_REPLY_BUILDER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define ARP_RB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("arp_rb assertion failed");
`define ARP_RB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("arp_rb assertion failed");
`else
`define ARP_RB_ASSERT(lbl, clk, rst_n, prop)
`define ARP_RB_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/arp_rb_pkg.sv
package arp_rb_pkg;

    localparam int MAC_W       = 48;
    localparam int IP_W        = 32;
    localparam int HDR_W       = 64;
    localparam int CNT_W       = 5;
    localparam int CNT_MAX     = (1 << CNT_W) - 1;
    localparam int FRAME_BYTES = 42;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int FRAME_W     = FRAME_BYTES * 8;
    localparam int FIFO_DEPTH  = 2;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [CNT_W-1:0] POS_SMAC  = CNT_W'(8);
    localparam logic [CNT_W-1:0] POS_SIP   = CNT_W'(14);
    localparam logic [CNT_W-1:0] POS_THA   = CNT_W'(18);
    localparam logic [CNT_W-1:0] POS_TIP   = CNT_W'(24);
    localparam logic [CNT_W-1:0] POS_END   = CNT_W'(28);
    localparam logic [CNT_W-1:0] POS_FINAL = CNT_W'(27);

    localparam logic [15:0] HTYPE_ETH   = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  HLEN_ETH    = 8'd6;
    localparam logic [7:0]  PLEN_IPV4   = 8'd4;
    localparam logic [15:0] OP_REQUEST  = 16'h0001;
    localparam logic [15:0] OP_REPLY    = 16'h0002;
    localparam logic [15:0] ETYPE_ARP   = 16'h0806;

    typedef struct packed {
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  sender_ip;
        logic [IP_W-1:0]  target_ip;
    } t_desc;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [FCNT_W-1:0] count;
    } t_fifo_status;

    function automatic logic [7:0] frame_byte(input logic [IDX_W-1:0] idx,
                                              input t_desc d,
                                              input logic [MAC_W-1:0] own_mac);
        logic [FRAME_W-1:0] frame;
        frame = {d.sender_mac, own_mac, ETYPE_ARP,
                 HTYPE_ETH, PTYPE_IPV4, HLEN_ETH, PLEN_IPV4, OP_REPLY,
                 own_mac, d.target_ip, d.sender_mac, d.sender_ip};
        return frame[(FRAME_BYTES - 1 - int'(idx)) * 8 +: 8];
    endfunction

endpackage

### rtl/arp_rb_front.sv
module arp_rb_front import arp_rb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_push,
    output t_desc       o_desc
);

    logic [CNT_W-1:0] r_count, n_count;
    logic [HDR_W-1:0] r_header, n_header;
    logic [MAC_W-1:0] r_sender_mac, n_sender_mac;
    logic [IP_W-1:0]  r_sender_ip, n_sender_ip;
    logic [IP_W-1:0]  r_target_ip, n_target_ip;
    logic             hdr_ok;

    always_comb begin
        n_header     = r_header;
        n_sender_mac = r_sender_mac;
        n_sender_ip  = r_sender_ip;
        n_target_ip  = r_target_ip;
        n_count      = r_count;
        if (r_count < POS_SMAC) begin
            n_header = {r_header[HDR_W-9:0], i_data_byte};
        end else if (r_count < POS_SIP) begin
            n_sender_mac = {r_sender_mac[MAC_W-9:0], i_data_byte};
        end else if (r_count < POS_THA) begin
            n_sender_ip = {r_sender_ip[IP_W-9:0], i_data_byte};
        end else if (r_count >= POS_TIP && r_count < POS_END) begin
            n_target_ip = {r_target_ip[IP_W-9:0], i_data_byte};
        end
        if (i_last_byte) begin
            n_count = '0;
        end else if (r_count != CNT_W'(CNT_MAX)) begin
            n_count = r_count + 1'b1;
        end
    end

    assign hdr_ok = (r_header[63:48] == HTYPE_ETH) && (r_header[47:32] == PTYPE_IPV4) &&
                    (r_header[31:24] == HLEN_ETH) && (r_header[23:16] == PLEN_IPV4) &&
                    (r_header[15:0] == OP_REQUEST);

    assign o_push = i_accept && i_last_byte && (r_count >= POS_FINAL) && hdr_ok;
    assign o_desc = '{sender_mac: n_sender_mac, sender_ip: n_sender_ip,
                      target_ip: n_target_ip};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_header     <= '0;
            r_sender_mac <= '0;
            r_sender_ip  <= '0;
            r_target_ip  <= '0;
        end else if (i_accept) begin
            r_count      <= n_count;
            r_header     <= n_header;
            r_sender_mac <= n_sender_mac;
            r_sender_ip  <= n_sender_ip;
            r_target_ip  <= n_target_ip;
        end
    end

endmodule

### rtl/arp_rb_fifo.sv
module arp_rb_fifo import arp_rb_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_desc        i_desc,
    input  logic         i_pop,
    output t_desc        o_desc,
    output t_fifo_status o_status
);

    t_desc             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_desc         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == FCNT_W'(FIFO_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

endmodule

### rtl/arp_rb_back.sv
module arp_rb_back import arp_rb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_desc            i_desc,
    input  logic [MAC_W-1:0] i_own_mac,
    input  logic             i_out_ready,
    output logic             o_pop,
    output logic [IDX_W-1:0] o_idx,
    output logic             o_out_valid,
    output logic [7:0]       o_reply_byte,
    output logic             o_reply_last
);

    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_last;
    logic             load;
    logic             at_end;

    assign load   = (!r_valid || i_out_ready) && !i_empty;
    assign at_end = (r_idx == IDX_W'(FRAME_BYTES - 1));
    assign o_pop  = load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? '0 : r_idx + 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= frame_byte(r_idx, i_desc, i_own_mac);
            r_last <= at_end;
        end
    end

    assign o_idx        = r_idx;
    assign o_out_valid  = r_valid;
    assign o_reply_byte = r_byte;
    assign o_reply_last = r_last;

endmodule

### rtl/arp_reply_builder_top.sv
// ARP responder: takes ARP payload bytes (from the hardware type field on) one beat
// per cycle while the queue is not full and, when a packet of at least 28 bytes
// ends with a valid Ethernet/IPv4 request, sends a 42-byte Ethernet frame with the
// ARP reply, one beat per cycle while the output is ready, addressed to the
// requester and sourced from own_mac. A passing request is handed over on its last
// beat to a two-entry queue; the sender registers each byte of the frame, 42 beats
// per reply, so under a steady stream of minimum length requests the input stalls
// while both queue entries are taken. The user must write own_mac on the config
// channel only while no reply is pending; the block does not enforce this.
`include "arp_reply_builder_top_macros.svh"

module arp_reply_builder_top import arp_rb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [MAC_W-1:0] i_own_mac,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_reply_byte,
    output logic             o_reply_last
);

    logic [MAC_W-1:0] r_own_mac;
    logic             accept;
    logic             push;
    logic             pop;
    t_desc            push_desc;
    t_desc            head_desc;
    t_fifo_status     fifo_st;
    logic [IDX_W-1:0] back_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= '0;
        end else if (i_cfg_valid) begin
            r_own_mac <= i_own_mac;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !fifo_st.full;
    assign accept      = i_in_valid && o_in_ready;

    arp_rb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push),
        .o_desc      (push_desc)
    );

    arp_rb_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_desc   (push_desc),
        .i_pop    (pop),
        .o_desc   (head_desc),
        .o_status (fifo_st)
    );

    arp_rb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (fifo_st.empty),
        .i_desc       (head_desc),
        .i_own_mac    (r_own_mac),
        .i_out_ready  (i_out_ready),
        .o_pop        (pop),
        .o_idx        (back_idx),
        .o_out_valid  (o_out_valid),
        .o_reply_byte (o_reply_byte),
        .o_reply_last (o_reply_last)
    );

    // queue bookkeeping and sender position
    `ARP_RB_ASSERT(a_no_push_full, i_clk, i_rst_n, !(push && fifo_st.full))
    `ARP_RB_ASSERT(a_no_pop_empty, i_clk, i_rst_n, !(pop && fifo_st.empty))
    `ARP_RB_ASSERT(a_idle_at_start, i_clk, i_rst_n, fifo_st.empty |-> (back_idx == '0))
    `ARP_RB_ASSERT(a_pop_ends_frame, i_clk, i_rst_n, pop |=> (o_out_valid && o_reply_last))

endmodule
